@@ rtl/http_json_field_extractor_core_macros.svh @@
// Assertion macros used by the checker file of the field extractor.
`ifndef HTTP_JSON_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define HTTP_JSON_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HJFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define HJFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hjfe_pkg.sv @@
// Shared constants, register codes and key tables of the field extractor.
package hjfe_pkg;

  // Matcher lengths
  localparam logic [2:0] HDR_LEN      = 3'd4;
  localparam logic [3:0] TEMP_KEY_LEN = 4'd9;
  localparam logic [3:0] TEXT_KEY_LEN = 4'd8;

  // Value terminators
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;

  // Register index codes (paddr[2])
  localparam logic REG_TEMP_MAX = 1'b0;
  localparam logic REG_TEXT_MAX = 1'b1;

  // Register reset values
  localparam logic [7:0] TEMP_MAX_RST = 8'd15;
  localparam logic [7:0] TEXT_MAX_RST = 8'd31;

  // Result tdata layout
  localparam int O_HDR        = 0;
  localparam int O_TEMP_VALID = 1;
  localparam int O_TEMP_LSB   = 2;
  localparam int O_TEMP_END   = 10;
  localparam int O_TEXT_VALID = 11;
  localparam int O_TEXT_LSB   = 12;
  localparam int O_TEXT_END   = 20;
  localparam int O_BOTH       = 21;
  localparam int O_FINISHED   = 22;
  localparam int OUT_W        = 24;

  // CR LF CR LF
  function automatic logic [7:0] hdr_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h0D;
      2'd1:    c = 8'h0A;
      2'd2:    c = 8'h0D;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  // "temp_f":
  function automatic logic [7:0] temp_key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h22;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h65;
      4'd3:    c = 8'h6D;
      4'd4:    c = 8'h70;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h66;
      4'd7:    c = 8'h22;
      4'd8:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "text":"
  function automatic logic [7:0] text_key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h22;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h65;
      4'd3:    c = 8'h78;
      4'd4:    c = 8'h74;
      4'd5:    c = 8'h22;
      4'd6:    c = 8'h3A;
      4'd7:    c = 8'h22;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/http_json_field_extractor_core.sv @@
// Top level of the HTTP response field extractor: parser state, result register, APB registers.
//
// Usage:
//   Input stream s_*: one response byte per transfer in s_tdata; s_tuser = 1 marks a
//   restart, which clears all parse state (registers are kept) and yields an all-zero result.
//   Output stream m_*: exactly one result per input transfer, in order, in m_tdata.
//   APB port: register 0 (byte 0x0) max temperature bytes, register 1 (byte 0x4) max
//   text bytes; write only while the stream is idle. pready is always high.
// Latency: the result of a byte is valid the cycle after its transfer.
// Throughput: one byte per cycle while the result side is not stalled; the parser state and the single
//   result register are updated in the same cycle as the input transfer.
// Stall: while m_tvalid is high and m_tready low the result holds and s_tready is low;
//   a byte is taken in the same cycle the waiting result leaves.
// Reset (rst, synchronous): parse state cleared, output empty, registers back to 15 / 31.
module http_json_field_extractor_core (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] data_byte
  input  logic                        s_tuser,  // [0] req_type
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] headers_done, [1] temp_valid, [9:2] temp_byte, [10] temp_end,
  // [11] text_valid, [19:12] text_byte, [20] text_end, [21] both_found,
  // [22] finished, [23] zero
  output logic [hjfe_pkg::OUT_W-1:0]  m_tdata,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hjfe_pkg::*;

  // Configuration registers
  logic [7:0] max_temp_chars;
  logic [7:0] max_text_chars;

  // Parse state
  logic [2:0] header_progress,   header_progress_next;
  logic [3:0] temp_key_progress, temp_key_progress_next;
  logic [3:0] text_key_progress, text_key_progress_next;
  logic       temp_found,        temp_found_next;
  logic       text_found,        text_found_next;
  logic       temp_capturing,    temp_capturing_next;
  logic       text_capturing,    text_capturing_next;
  logic [7:0] temp_count,        temp_count_next;
  logic [7:0] text_count,        text_count_next;
  logic       done_flag,         done_flag_next;

  // Per-byte outputs
  logic       temp_valid, temp_end, text_valid, text_end;
  logic [7:0] temp_byte, text_byte;
  logic [OUT_W-1:0] result;

  logic in_xfer;
  logic cfg_wr;
  logic reg_idx;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign reg_idx  = paddr[2];
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      max_temp_chars <= TEMP_MAX_RST;
      max_text_chars <= TEXT_MAX_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TEMP_MAX: max_temp_chars <= pwdata[7:0];
        REG_TEXT_MAX: max_text_chars <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (reg_idx)
      REG_TEMP_MAX: prdata = {24'd0, max_temp_chars};
      REG_TEXT_MAX: prdata = {24'd0, max_text_chars};
      default:      prdata = 32'd0;
    endcase
  end

  // Parser next state for the byte on the input
  always_comb begin
    header_progress_next   = header_progress;
    temp_key_progress_next = temp_key_progress;
    text_key_progress_next = text_key_progress;
    temp_found_next        = temp_found;
    text_found_next        = text_found;
    temp_capturing_next    = temp_capturing;
    text_capturing_next    = text_capturing;
    temp_count_next        = temp_count;
    text_count_next        = text_count;
    done_flag_next         = done_flag;
    temp_valid = 1'b0;
    temp_byte  = 8'd0;
    temp_end   = 1'b0;
    text_valid = 1'b0;
    text_byte  = 8'd0;
    text_end   = 1'b0;

    if (s_tuser) begin
      header_progress_next   = 3'd0;
      temp_key_progress_next = 4'd0;
      text_key_progress_next = 4'd0;
      temp_found_next        = 1'b0;
      text_found_next        = 1'b0;
      temp_capturing_next    = 1'b0;
      text_capturing_next    = 1'b0;
      temp_count_next        = 8'd0;
      text_count_next        = 8'd0;
      done_flag_next         = 1'b0;
    end else if (done_flag) begin
      // finished: byte ignored
    end else if (header_progress < HDR_LEN) begin
      // header terminator; a mismatch restarts without rechecking the byte
      if (s_tdata == hdr_char(header_progress[1:0])) begin
        header_progress_next = header_progress + 3'd1;
      end else begin
        header_progress_next = 3'd0;
      end
    end else begin
      // temperature key / value
      if (!temp_found && !temp_capturing) begin
        if (temp_key_progress < TEMP_KEY_LEN &&
            s_tdata == temp_key_char(temp_key_progress)) begin
          temp_key_progress_next = temp_key_progress + 4'd1;
          if (temp_key_progress_next == TEMP_KEY_LEN) begin
            temp_found_next     = 1'b1;
            temp_capturing_next = 1'b1;
          end
        end else begin
          temp_key_progress_next = 4'd0;
        end
      end else if (temp_capturing) begin
        if (s_tdata == CHAR_COMMA || s_tdata == CHAR_RBRACE) begin
          temp_capturing_next = 1'b0;
          temp_end            = 1'b1;
        end else if (temp_count < max_temp_chars) begin
          temp_count_next = temp_count + 8'd1;
          temp_valid      = 1'b1;
          temp_byte       = s_tdata;
        end
      end

      // text key / value
      if (!text_found && !text_capturing) begin
        if (text_key_progress < TEXT_KEY_LEN &&
            s_tdata == text_key_char(text_key_progress)) begin
          text_key_progress_next = text_key_progress + 4'd1;
          if (text_key_progress_next == TEXT_KEY_LEN) begin
            text_found_next     = 1'b1;
            text_capturing_next = 1'b1;
          end
        end else begin
          text_key_progress_next = 4'd0;
        end
      end else if (text_capturing) begin
        if (s_tdata == CHAR_QUOTE) begin
          text_capturing_next = 1'b0;
          text_end            = 1'b1;
        end else if (text_count < max_text_chars) begin
          text_count_next = text_count + 8'd1;
          text_valid      = 1'b1;
          text_byte       = s_tdata;
        end
      end

      if (!temp_capturing_next && !text_capturing_next && temp_found_next && text_found_next) begin
        done_flag_next = 1'b1;
      end
    end
  end

  // Result word from the state after this byte
  always_comb begin
    result                           = '0;
    result[O_HDR]                    = (header_progress_next >= HDR_LEN);
    result[O_TEMP_VALID]             = temp_valid;
    result[O_TEMP_LSB +: 8]          = temp_byte;
    result[O_TEMP_END]               = temp_end;
    result[O_TEXT_VALID]             = text_valid;
    result[O_TEXT_LSB +: 8]          = text_byte;
    result[O_TEXT_END]               = text_end;
    result[O_BOTH]                   = temp_found_next && text_found_next;
    result[O_FINISHED]               = done_flag_next;
  end

  // Parse state update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      header_progress   <= 3'd0;
      temp_key_progress <= 4'd0;
      text_key_progress <= 4'd0;
      temp_found        <= 1'b0;
      text_found        <= 1'b0;
      temp_capturing    <= 1'b0;
      text_capturing    <= 1'b0;
      temp_count        <= 8'd0;
      text_count        <= 8'd0;
      done_flag         <= 1'b0;
    end else if (in_xfer) begin
      header_progress   <= header_progress_next;
      temp_key_progress <= temp_key_progress_next;
      text_key_progress <= text_key_progress_next;
      temp_found        <= temp_found_next;
      text_found        <= text_found_next;
      temp_capturing    <= temp_capturing_next;
      text_capturing    <= text_capturing_next;
      temp_count        <= temp_count_next;
      text_count        <= text_count_next;
      done_flag         <= done_flag_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= in_xfer || (m_tvalid && !m_tready);
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= result;
    end
  end

endmodule

@@ rtl/hjfe_checker.sv @@
// Port-level assertion checker for the field extractor, bound to the top level.
`include "http_json_field_extractor_core_macros.svh"

module hjfe_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [hjfe_pkg::OUT_W-1:0] m_tdata
);
  import hjfe_pkg::*;

  // A waiting result blocks the input side
  `HJFE_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while result stalled")

  // Stalled result holds
  `HJFE_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // Finished implies header seen and both keys found
  `HJFE_ASSERT_NOW(a_finished_flags, m_tvalid && m_tdata[O_FINISHED], m_tdata[O_HDR] && m_tdata[O_BOTH], "finished without header or keys")

  // A restart transfer gives an all-zero result next cycle
  `HJFE_ASSERT_NEXT(a_restart_zero, s_tvalid && s_tready && s_tuser, m_tvalid && (m_tdata == '0), "restart result not zero")

endmodule

bind http_json_field_extractor_core hjfe_checker u_hjfe_checker (.*);

@@ sim/tb_http_json_field_extractor_core.sv @@
// Self-checking testbench for the HTTP response field extractor core.
`timescale 1ns / 1ps

module tb_http_json_field_extractor_core;
  import hjfe_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES  = 6;

  // Request codes carried in s_tuser
  localparam logic REQ_DATA    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Register byte addresses
  localparam logic [2:0] ADDR_TEMP_MAX = {REG_TEMP_MAX, 2'b00};
  localparam logic [2:0] ADDR_TEXT_MAX = {REG_TEXT_MAX, 2'b00};

  // Keys as byte strings, first character in the top byte
  localparam logic [8*9-1:0] TEMP_KEY_STR = "\"temp_f\":";
  localparam logic [8*8-1:0] TEXT_KEY_STR = "\"text\":\"";

  typedef struct packed {
    logic       headers_done;
    logic       temp_valid;
    logic [7:0] temp_byte;
    logic       temp_end;
    logic       text_valid;
    logic [7:0] text_byte;
    logic       text_end;
    logic       both_found;
    logic       finished;
  } fields_t;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       fixed;
    fields_t    want;
  } dir_row_t;

  localparam fields_t NO_FIELDS = '0;
  localparam int DIR_N = 21;

  // Directed rows: restarts and the first two data rows carry a typed result, the rest go through the parser model.
  // Run with max_temp_chars = 0 and max_text_chars = 1.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{REQ_RESTART, 8'hFF, 1'b1, NO_FIELDS},  // restart, data ignored
    '{REQ_DATA,    8'h00, 1'b1, NO_FIELDS},  // lowest byte, still in header
    '{REQ_DATA,    8'hFF, 1'b1, NO_FIELDS},  // highest byte, still in header
    '{REQ_DATA,    8'h0D, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h0D, 1'b0, NO_FIELDS},  // terminator mismatch, not rechecked
    '{REQ_DATA,    8'h0D, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h0A, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h0D, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h0A, 1'b0, NO_FIELDS},  // completes CR LF CR LF, consumed
    '{REQ_DATA,    8'h22, 1'b0, NO_FIELDS},  // "text":" - both matchers start
    '{REQ_DATA,    8'h74, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h65, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h78, 1'b0, NO_FIELDS},  // temp matcher drops out
    '{REQ_DATA,    8'h74, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h22, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h3A, 1'b0, NO_FIELDS},
    '{REQ_DATA,    8'h22, 1'b0, NO_FIELDS},  // key complete, not captured
    '{REQ_DATA,    8'h78, 1'b0, NO_FIELDS},  // kept
    '{REQ_DATA,    8'h79, 1'b0, NO_FIELDS},  // over the limit, dropped
    '{REQ_DATA,    8'h22, 1'b0, NO_FIELDS},  // text terminator
    '{REQ_RESTART, 8'h00, 1'b1, NO_FIELDS}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Parser model state
  logic [7:0] cfg_temp_max;
  logic [7:0] cfg_text_max;
  logic [2:0] hdr_prog;
  logic [3:0] tkey_prog;
  logic [3:0] xkey_prog;
  logic       t_found;
  logic       x_found;
  logic       t_cap;
  logic       x_cap;
  logic [7:0] t_cnt;
  logic [7:0] x_cnt;
  logic       done_f;

  fields_t    expected_fields [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         cycles = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;

  http_json_field_extractor_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] temp_key_at(input logic [3:0] i);
    return TEMP_KEY_STR[8*(int'(TEMP_KEY_LEN) - 1 - int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] text_key_at(input logic [3:0] i);
    return TEXT_KEY_STR[8*(int'(TEXT_KEY_LEN) - 1 - int'(i)) +: 8];
  endfunction

  // Mostly no gap, some short, a few long; none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_parse();
    hdr_prog  = '0;
    tkey_prog = '0;
    xkey_prog = '0;
    t_found   = 1'b0;
    x_found   = 1'b0;
    t_cap     = 1'b0;
    x_cap     = 1'b0;
    t_cnt     = '0;
    x_cnt     = '0;
    done_f    = 1'b0;
  endtask

  // Advance the parser model by one accepted item and return its result
  task automatic track_parser(input logic req, input logic [7:0] c, output fields_t r);
    r = NO_FIELDS;
    if (req == REQ_RESTART) begin
      clear_parse();
    end else if (done_f) begin
      // finished: byte ignored
    end else if (hdr_prog < HDR_LEN) begin
      if (c == (hdr_prog[0] ? 8'h0A : 8'h0D)) hdr_prog = hdr_prog + 3'd1;
      else hdr_prog = '0;
    end else begin
      // temperature key and value
      if (!t_found && !t_cap) begin
        if (tkey_prog < TEMP_KEY_LEN && c == temp_key_at(tkey_prog)) begin
          tkey_prog = tkey_prog + 4'd1;
          if (tkey_prog == TEMP_KEY_LEN) begin
            t_found = 1'b1;
            t_cap   = 1'b1;
          end
        end else begin
          tkey_prog = '0;
        end
      end else if (t_cap) begin
        if (c == CHAR_COMMA || c == CHAR_RBRACE) begin
          t_cap      = 1'b0;
          r.temp_end = 1'b1;
        end else if (t_cnt < cfg_temp_max) begin
          t_cnt        = t_cnt + 8'd1;
          r.temp_valid = 1'b1;
          r.temp_byte  = c;
        end
      end
      // condition text key and value
      if (!x_found && !x_cap) begin
        if (xkey_prog < TEXT_KEY_LEN && c == text_key_at(xkey_prog)) begin
          xkey_prog = xkey_prog + 4'd1;
          if (xkey_prog == TEXT_KEY_LEN) begin
            x_found = 1'b1;
            x_cap   = 1'b1;
          end
        end else begin
          xkey_prog = '0;
        end
      end else if (x_cap) begin
        if (c == CHAR_QUOTE) begin
          x_cap      = 1'b0;
          r.text_end = 1'b1;
        end else if (x_cnt < cfg_text_max) begin
          x_cnt        = x_cnt + 8'd1;
          r.text_valid = 1'b1;
          r.text_byte  = c;
        end
      end
      if (!t_cap && !x_cap && t_found && x_found) done_f = 1'b1;
    end
    r.headers_done = (hdr_prog >= HDR_LEN);
    r.both_found   = t_found && x_found;
    r.finished     = done_f;
  endtask

  // One input transfer; the result is predicted once the byte is taken
  task automatic send_item(input logic req, input logic [7:0] data, input logic fixed,
                           input fields_t want);
    int      gap;
    fields_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    track_parser(req, data, pred);
    expected_fields.push_back(fixed ? want : pred);
    items_sent++;
  endtask

  task automatic send_data(input logic [7:0] data);
    send_item(REQ_DATA, data, 1'b0, NO_FIELDS);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup then access, then back to idle
  task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_TEMP_MAX) cfg_temp_max = val;
    else cfg_text_max = val;
    @(posedge clk);
  endtask

  function automatic int value_len(input bit long_run);
    if (long_run) return $urandom_range(250, 270);
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 6);
    return $urandom_range(7, 40);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // Printable filler between fields, sometimes a key prefix cut short
  task automatic send_filler(input bit temp_side);
    int k;
    repeat ($urandom_range(0, 3)) send_data(printable());
    if ($urandom_range(0, 3) == 0) begin
      k = temp_side ? $urandom_range(1, int'(TEMP_KEY_LEN) - 1)
                    : $urandom_range(1, int'(TEXT_KEY_LEN) - 1);
      for (int i = 0; i < k; i++)
        send_data(temp_side ? temp_key_at(4'(i)) : text_key_at(4'(i)));
      send_data(8'h71);  // 'q' breaks either key
    end
  endtask

  task automatic send_temp_field(input bit long_run);
    logic [7:0] b;
    int         n;
    send_filler(1'b1);
    for (int i = 0; i < int'(TEMP_KEY_LEN); i++) send_data(temp_key_at(4'(i)));
    n = value_len(long_run);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        b = 8'($urandom_range(8'h30, 8'h39));
      end else begin
        do b = 8'($urandom()); while (b == CHAR_COMMA || b == CHAR_RBRACE);
      end
      send_data(b);
    end
    send_data($urandom_range(0, 1) ? CHAR_COMMA : CHAR_RBRACE);
  endtask

  task automatic send_text_field(input bit long_run);
    logic [7:0] b;
    int         n;
    send_filler(1'b0);
    for (int i = 0; i < int'(TEXT_KEY_LEN); i++) send_data(text_key_at(4'(i)));
    n = value_len(long_run);
    repeat (n) begin
      do b = ($urandom_range(0, 9) < 7) ? printable() : 8'($urandom());
      while (b == CHAR_QUOTE);
      send_data(b);
    end
    send_data(CHAR_QUOTE);
  endtask

  // A well-formed response: usually a restart, header, both fields in either order, trailing bytes
  task automatic send_response(input bit long_run);
    if ($urandom_range(0, 19) != 0) send_item(REQ_RESTART, 8'($urandom()), 1'b0, NO_FIELDS);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 9) == 0) send_data($urandom_range(0, 1) ? 8'h0D : 8'h0A);
      else send_data(printable());
    end
    send_data(printable());
    // near miss on the terminator
    if ($urandom_range(0, 3) == 0) begin
      send_data(8'h0D);
      send_data(8'h0A);
      send_data(8'h0D);
      send_data(printable());
    end
    send_data(8'h0D);
    send_data(8'h0A);
    send_data(8'h0D);
    send_data(8'h0A);
    if ($urandom_range(0, 1)) begin
      send_temp_field(long_run);
      send_text_field(long_run);
    end else begin
      send_text_field(long_run);
      send_temp_field(long_run);
    end
    repeat ($urandom_range(0, 4)) send_data(8'($urandom()));
  endtask

  // Raw noise: any byte, occasional restart
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item(($urandom_range(0, 9) == 0) ? REQ_RESTART : REQ_DATA, 8'($urandom()),
                1'b0, NO_FIELDS);
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input logic [OUT_W-1:0] word);
    fields_t want;
    if (expected_fields.size() == 0) begin
      $display("%0t: result %h with none expected, expected none actual %h", $time, word, word);
      mismatches++;
    end else begin
      want = expected_fields.pop_front();
      cmp_field("headers_done", 8'(want.headers_done), 8'(word[O_HDR]));
      cmp_field("temp_valid",   8'(want.temp_valid),   8'(word[O_TEMP_VALID]));
      cmp_field("temp_byte",    want.temp_byte,        word[O_TEMP_LSB +: 8]);
      cmp_field("temp_end",     8'(want.temp_end),     8'(word[O_TEMP_END]));
      cmp_field("text_valid",   8'(want.text_valid),   8'(word[O_TEXT_VALID]));
      cmp_field("text_byte",    want.text_byte,        word[O_TEXT_LSB +: 8]);
      cmp_field("text_end",     8'(want.text_end),     8'(word[O_TEXT_END]));
      cmp_field("both_found",   8'(want.both_found),   8'(word[O_BOTH]));
      cmp_field("finished",     8'(want.finished),     8'(word[O_FINISHED]));
    end
  endtask

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Main sequence
  initial begin
    int         phase_end;
    bit         long_run;
    logic [7:0] tmax;
    logic [7:0] xmax;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_DATA;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    cfg_temp_max = TEMP_MAX_RST;
    cfg_text_max = TEXT_MAX_RST;
    clear_parse();

    // Directed table
    write_reg(ADDR_TEMP_MAX, 8'd0);
    write_reg(ADDR_TEXT_MAX, 8'd1);
    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_TAB[i].req, DIR_TAB[i].data, DIR_TAB[i].fixed, DIR_TAB[i].want);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin tmax = 8'd0;   xmax = 8'd0;   end
        1: begin tmax = 8'd255; xmax = 8'd255; end
        2: begin tmax = 8'd15;  xmax = 8'd31;  end
        3: begin tmax = 8'd1;   xmax = 8'd2;   end
        4: begin tmax = 8'($urandom()); xmax = 8'($urandom()); end
        default: begin
          tmax = 8'($urandom_range(0, 8));
          xmax = 8'($urandom_range(0, 8));
        end
      endcase
      write_reg(ADDR_TEMP_MAX, tmax);
      write_reg(ADDR_TEXT_MAX, xmax);
      quiet     = (ph == 2);
      long_run  = (ph == 1);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8) begin
          send_response(long_run);
          long_run = 1'b0;
        end else begin
          send_noise();
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hjfe_pkg.sv
rtl/http_json_field_extractor_core.sv
rtl/hjfe_checker.sv
sim/tb_http_json_field_extractor_core.sv
